// File: sv/aes_pkg.sv
`default_nettype none
package aes_pkg;

	localparam int RkDepth = 60;
	localparam int RkAw = $clog2(RkDepth);

	typedef enum logic [1:0] {
		KL_128 = 2'd0,
		KL_192 = 2'd1,
		KL_256 = 2'd2,
		KL_RSVD = 2'd3
	} key_len_t;

	typedef enum logic [2:0] {
		REG_KEY_LENGTH = 3'd0,
		REG_KEY_0_7 = 3'd1,
		REG_KEY_8_15 = 3'd2,
		REG_KEY_16_23 = 3'd3,
		REG_KEY_24_31 = 3'd4
	} reg_idx_t;

	localparam logic [1:0] KeyLenReset = KL_128;
	localparam logic [63:0] Key0Reset = 64'h0f1571c947d9e859;
	localparam logic [63:0] Key1Reset = 64'h0cb7add6af7f6798;

	typedef struct packed {
		logic mode;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	// round-key write port from the key schedule
	typedef struct packed {
		logic we;
		logic [RkAw-1:0] addr;
		logic [31:0] data;
	} rk_wr_t;

	typedef enum logic [1:0] {
		KS_IDLE = 2'd0,
		KS_RUN = 2'd1
	} ks_state_t;

	typedef enum logic [1:0] {
		CS_IDLE = 2'd0,
		CS_FIRST = 2'd1,
		CS_ROUND = 2'd2,
		CS_DONE = 2'd3
	} cs_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [3:0] num_rounds(input logic [1:0] kl);
		case (kl)
			KL_128: num_rounds = 4'd10;
			KL_192: num_rounds = 4'd12;
			default: num_rounds = 4'd14;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: sv/aes_key_sched.sv
`default_nettype none
// Produces one round-key word per cycle from a sliding window of the last Nk words.
module aes_key_sched import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic kick,
	input wire logic [1:0] key_length,
	input wire logic [255:0] key,
	output logic busy,
	output rk_wr_t rk_wr
);

	ks_state_t state_q, state_d;
	logic [31:0] win_q [8];
	logic [5:0] idx_q;
	logic [2:0] pos_q;
	logic [7:0] rc_q;
	logic [3:0] nk;
	logic [5:0] total;
	logic [31:0] prev, oldw, t, neww;
	logic load, adv;

	always_comb begin
		case (key_length)
			KL_128: nk = 4'd4;
			KL_192: nk = 4'd6;
			default: nk = 4'd8;
		endcase
		total = 6'((num_rounds(key_length) + 5'd1) * 4);
	end

	// window: win_q[0] is w[i-nk], win_q[nk-1] is w[i-1]
	always_comb begin
		prev = win_q[3'(nk - 4'd1)];
		oldw = win_q[0];
		if (pos_q == 3'd0 && idx_q >= 6'(nk))
			t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
		else if (nk == 4'd8 && pos_q == 3'd4)
			t = sub_word(prev);
		else
			t = prev;
		neww = (idx_q < 6'(nk)) ? key[255 - 32*idx_q[2:0] -: 32] : (t ^ oldw);
	end

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		adv = 1'b0;
		case (state_q)
			KS_IDLE: if (kick) begin
				state_d = KS_RUN;
				load = 1'b1;
			end
			KS_RUN: begin
				if (kick) load = 1'b1;
				else begin
					adv = 1'b1;
					if (idx_q == 6'(RkDepth - 1)) state_d = KS_IDLE;
				end
			end
			default: state_d = KS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			idx_q <= '0;
			pos_q <= '0;
			rc_q <= 8'h01;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q <= '0;
				pos_q <= '0;
				rc_q <= 8'h01;
			end else if (adv) begin
				idx_q <= idx_q + 6'd1;
				pos_q <= (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
				if (pos_q == 3'd0 && idx_q >= 6'(nk)) rc_q <= xtime(rc_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (idx_q < 6'(nk)) begin
				win_q[idx_q[2:0]] <= neww;
			end else begin
				for (int i = 0; i < 7; i++)
					if (i < int'(nk) - 1) win_q[i] <= win_q[i+1];
				win_q[3'(nk - 4'd1)] <= neww;
			end
		end
	end

	always_comb begin
		rk_wr.we = adv;
		rk_wr.addr = idx_q;
		rk_wr.data = (idx_q < total) ? neww : 32'h0;
	end

	assign busy = (state_q != KS_IDLE) || kick;

endmodule
`default_nettype wire

// File: sv/aes_round.sv
`default_nettype none
// One full round as combinational logic, forward or inverse.
module aes_round import aes_pkg::*; (
	input wire logic [127:0] st,
	input wire logic inv,
	input wire logic last,
	input wire logic [127:0] rk,
	output logic [127:0] nxt
);

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;

	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv) t[4*((c + r) % 4) + r] = ISBOX[s[4*c + r]];
				else t[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
			end
		// inverse: add key before mix
		if (inv)
			for (int i = 0; i < 16; i++) t[i] = t[i] ^ rk[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
			if (inv) begin
				// 0e,0b,0d,09 by pre-mixing with 04/05 then forward mix
				y0 = xtime(xtime(a0 ^ a2));
				y1 = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ y0; a1 = a1 ^ y1; a2 = a2 ^ y0; a3 = a3 ^ y1;
				x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
			end
			y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
			y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
			y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
			y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
			m[4*c] = y0; m[4*c+1] = y1; m[4*c+2] = y2; m[4*c+3] = y3;
		end
		for (int i = 0; i < 16; i++) begin
			if (inv) nxt[127 - 8*i -: 8] = last ? t[i] : m[i];
			else nxt[127 - 8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127 - 8*i -: 8];
		end
	end

endmodule
`default_nettype wire

// File: sv/aes_block_cipher_core.sv
`default_nettype none
// Channel   | Ports                           | Transaction
// ----------+---------------------------------+--------------------------------
// command   | start, busy, cmd                | start & !busy
// result    | done, result                    | done (one cycle, no back-pressure)
// config    | cfg_we, cfg_index, cfg_wdata    | cfg_we
// An item goes from state FIRST, which does the first key addition, through one ROUND
// state per round, with each round's key row read from memory in the state before.
// busy stays high in the done state, so the next item is taken only once the core is
// back in idle.
// After reset, and after each config write to a mapped register, the key schedule
// writes 60 words; busy is high meanwhile and no item is taken.
// The result is shown for one cycle on done; the receiver cannot stall.
module aes_block_cipher_core import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire aes_in_t cmd,
	output logic done,
	output aes_out_t result,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_wdata
);

	localparam int RowAw = RkAw - 2;
	localparam int Rows = (RkDepth + 3) / 4;

	logic [1:0] klen_q;
	logic [63:0] key_q [4];
	logic kick_q;
	logic ks_busy;
	rk_wr_t rk_wr;
	logic [255:0] key_all;

	// round keys stored as rows of four words
	logic [127:0] rk_mem [Rows];
	logic [127:0] rk_rd_q;
	logic [RowAw-1:0] rd_row;

	cs_state_t state_q, state_d;
	logic [127:0] st_q, rnd_out;
	logic mode_q;
	logic [3:0] rnd_q, nr;
	logic [127:0] res_q;
	logic done_q;
	logic accept, valid_idx;

	assign valid_idx = (cfg_index == REG_KEY_LENGTH) || (cfg_index == REG_KEY_0_7) ||
		(cfg_index == REG_KEY_8_15) || (cfg_index == REG_KEY_16_23) ||
		(cfg_index == REG_KEY_24_31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KeyLenReset;
			key_q[0] <= Key0Reset;
			key_q[1] <= Key1Reset;
			key_q[2] <= '0;
			key_q[3] <= '0;
			kick_q <= 1'b1;
		end else begin
			kick_q <= cfg_we && valid_idx;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: klen_q <= cfg_wdata[1:0];
					REG_KEY_0_7: key_q[0] <= cfg_wdata;
					REG_KEY_8_15: key_q[1] <= cfg_wdata;
					REG_KEY_16_23: key_q[2] <= cfg_wdata;
					REG_KEY_24_31: key_q[3] <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	assign key_all = {key_q[0], key_q[1], key_q[2], key_q[3]};

	aes_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .kick(kick_q), .key_length(klen_q),
		.key(key_all), .busy(ks_busy), .rk_wr(rk_wr)
	);

	// word write into a row: byte-lane style enable per word
	always_ff @(posedge clk) begin
		if (rk_wr.we) begin
			case (rk_wr.addr[1:0])
				2'd0: rk_mem[rk_wr.addr[RkAw-1:2]][127:96] <= rk_wr.data;
				2'd1: rk_mem[rk_wr.addr[RkAw-1:2]][95:64] <= rk_wr.data;
				2'd2: rk_mem[rk_wr.addr[RkAw-1:2]][63:32] <= rk_wr.data;
				default: rk_mem[rk_wr.addr[RkAw-1:2]][31:0] <= rk_wr.data;
			endcase
		end
		rk_rd_q <= rk_mem[rd_row];
	end

	assign nr = num_rounds(klen_q);
	assign accept = start && !busy;
	assign busy = ks_busy || cfg_we || (state_q != CS_IDLE);

	// rnd_q is the round being computed; rd_row fetches the next round's row
	always_comb begin
		state_d = state_q;
		rd_row = RowAw'(rnd_q);
		case (state_q)
			CS_IDLE: begin
				rd_row = accept ? (cmd.mode ? RowAw'(nr) : '0) : RowAw'(rnd_q);
				if (accept) state_d = CS_FIRST;
			end
			CS_FIRST: begin
				rd_row = RowAw'(mode_q ? rnd_q - 4'd1 : rnd_q + 4'd1);
				state_d = CS_ROUND;
			end
			CS_ROUND: begin
				if ((mode_q && rnd_q == 4'd0) || (!mode_q && rnd_q == nr))
					state_d = CS_DONE;
				else
					rd_row = RowAw'(mode_q ? rnd_q - 4'd1 : rnd_q + 4'd1);
			end
			CS_DONE: state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	aes_round u_round (
		.st(st_q), .inv(mode_q),
		.last(mode_q ? (rnd_q == 4'd0) : (rnd_q == nr)),
		.rk(rk_rd_q), .nxt(rnd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			rnd_q <= '0;
			mode_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			case (state_q)
				CS_IDLE: if (accept) begin
					mode_q <= cmd.mode;
					rnd_q <= cmd.mode ? nr : 4'd0;
				end
				CS_FIRST: rnd_q <= mode_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				CS_ROUND: begin
					if (state_d == CS_DONE) done_q <= 1'b1;
					else rnd_q <= mode_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: if (accept) st_q <= {cmd.block_high, cmd.block_low};
			CS_FIRST: st_q <= st_q ^ rk_rd_q;
			CS_ROUND: begin
				st_q <= rnd_out;
				if (state_d == CS_DONE) res_q <= rnd_out;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

// File: sv/aes_core_checker.sv
`default_nettype none
module aes_core_checker import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_we
);

	// a transaction makes the core busy next cycle
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after start");

	// done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// no result without a prior transaction being in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done out of nowhere");

	// a config write blocks commands in the same cycle
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> busy) else $error("config write not busy");

endmodule

bind aes_block_cipher_core aes_core_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .cfg_we(cfg_we)
);
`default_nettype wire

// File: sim/aes_block_cipher_checker.sv
`default_nettype none
module aes_block_cipher_checker import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire aes_in_t cmd,
	input wire logic done,
	input wire aes_out_t result,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_wdata,
	output int errors,
	output int outstanding
);

	logic [1:0] key_len;
	logic [63:0] key_regs [4];
	logic [31:0] round_keys [RkDepth];
	aes_out_t expected_blocks [$];

	function automatic logic [7:0] gf_mul(input logic [7:0] v, input logic [3:0] k);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 4; i++) begin
			if (k[i])
				acc ^= v;
			v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic logic [31:0] rot_sub(input logic [31:0] w, input bit rot);
		logic [31:0] t;
		t = rot ? {w[23:0], w[31:24]} : w;
		return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
	endfunction

	task automatic expand_key();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0] rcon;
		int nk, total;
		nk = (key_len == KL_128) ? 4 : (key_len == KL_192) ? 6 : 8;
		total = 4 * (nk + 7);
		rcon = 8'h01;
		for (int i = 0; i < 8; i++)
			w[i] = i[0] ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
		for (int i = nk; i < total; i++) begin
			t = w[i - 1];
			if (i % nk == 0) begin
				t = rot_sub(t, 1'b1) ^ {rcon, 24'h0};
				rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
			end else if (nk > 6 && i % nk == 4) begin
				t = rot_sub(t, 1'b0);
			end
			w[i] = t ^ w[i - nk];
		end
		for (int i = 0; i < RkDepth; i++)
			round_keys[i] = (i < total) ? w[i] : 32'h0;
	endtask

	function automatic logic [127:0] add_round_key(input logic [127:0] st, input int rnd);
		return st ^ {round_keys[4 * rnd], round_keys[4 * rnd + 1],
			round_keys[4 * rnd + 2], round_keys[4 * rnd + 3]};
	endfunction

	// byte k of the state sits at bits 127-8k downwards; byte 4c+r is row r, column c
	function automatic logic [127:0] sub_shift(input logic [127:0] st, input bit inv);
		logic [127:0] t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv)
					t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = ISBOX[st[127 - 8 * (4 * c + r) -: 8]];
				else
					t[127 - 8 * (4 * c + r) -: 8] = SBOX[st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
			end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] st, input bit inv);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [3:0] k0, k1, k2, k3;
		k0 = inv ? 4'he : 4'h2;
		k1 = inv ? 4'hb : 4'h3;
		k2 = inv ? 4'hd : 4'h1;
		k3 = inv ? 4'h9 : 4'h1;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++)
				a[r] = st[127 - 8 * (4 * c + r) -: 8];
			for (int r = 0; r < 4; r++)
				t[127 - 8 * (4 * c + r) -: 8] = gf_mul(a[r], k0) ^ gf_mul(a[(r + 1) % 4], k1)
					^ gf_mul(a[(r + 2) % 4], k2) ^ gf_mul(a[(r + 3) % 4], k3);
		end
		return t;
	endfunction

	function automatic aes_out_t cipher_block(input aes_in_t c);
		logic [127:0] st;
		int nr;
		nr = (key_len == KL_128) ? 10 : (key_len == KL_192) ? 12 : 14;
		st = {c.block_high, c.block_low};
		if (!c.mode) begin
			st = add_round_key(st, 0);
			for (int rnd = 1; rnd <= nr; rnd++) begin
				st = sub_shift(st, 1'b0);
				if (rnd != nr)
					st = mix_columns(st, 1'b0);
				st = add_round_key(st, rnd);
			end
		end else begin
			st = add_round_key(st, nr);
			for (int rnd = nr - 1; rnd >= 0; rnd--) begin
				st = sub_shift(st, 1'b1);
				st = add_round_key(st, rnd);
				if (rnd != 0)
					st = mix_columns(st, 1'b1);
			end
		end
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		aes_out_t want;
		if (!arst_n) begin
			key_len = KeyLenReset;
			key_regs[0] = Key0Reset;
			key_regs[1] = Key1Reset;
			key_regs[2] = 64'h0;
			key_regs[3] = 64'h0;
			expand_key();
			expected_blocks.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: begin
						key_len = cfg_wdata[1:0];
						expand_key();
					end
					REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31: begin
						key_regs[cfg_index - 1] = cfg_wdata;
						expand_key();
					end
					default: ;
				endcase
			end
			if (start && !busy)
				expected_blocks.push_back(cipher_block(cmd));
			if (done) begin
				if (expected_blocks.size() == 0) begin
					$error("result with no transaction outstanding: %h", result);
					errors++;
				end else begin
					want = expected_blocks.pop_front();
					if (result.result_high !== want.result_high) begin
						$error("result_high: expected %h, got %h", want.result_high,
							result.result_high);
						errors++;
					end
					if (result.result_low !== want.result_low) begin
						$error("result_low: expected %h, got %h", want.result_low,
							result.result_low);
						errors++;
					end
				end
			end
		end
		outstanding = expected_blocks.size();
	end

endmodule
`default_nettype wire

// File: sim/aes_block_cipher_core_tb.sv
`default_nettype none
module aes_block_cipher_core_tb import aes_pkg::*; ();

	localparam logic [2:0] RegUnmappedLow = 3'd5;
	localparam logic [2:0] RegUnmappedHigh = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	aes_in_t cmd = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	logic busy, done;
	aes_out_t result;
	int errors, outstanding;
	int idle_pct;

	always #2 clk = ~clk;

	aes_block_cipher_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	aes_block_cipher_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .errors(errors), .outstanding(outstanding)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; leaves start high after the transaction is taken
	task automatic encrypt_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = '{mode: mode, block_high: hi, block_low: lo};
		while (busy)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_key();
		logic [63:0] fill;
		fill = ($urandom_range(0, 7) == 0) ? '1 : ($urandom_range(0, 7) == 0) ? '0 : rand64();
		write_reg(REG_KEY_LENGTH, {62'($urandom), 2'($urandom_range(0, 3))});
		write_reg(REG_KEY_0_7, $urandom_range(0, 1) ? fill : rand64());
		write_reg(REG_KEY_8_15, rand64());
		write_reg(REG_KEY_16_23, $urandom_range(0, 1) ? fill : rand64());
		write_reg(REG_KEY_24_31, rand64());
	endtask

	initial begin
		idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// default key after reset, extreme blocks both ways
		encrypt_block(1'b0, '0, '0);
		encrypt_block(1'b1, '0, '0);
		encrypt_block(1'b0, '1, '1);
		encrypt_block(1'b1, '1, '1);
		encrypt_block(1'b0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
		// unmapped indexes must leave the key alone
		write_reg(RegUnmappedLow, '1);
		write_reg(RegUnmappedHigh, '1);
		encrypt_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		// every key length, including the reserved code, with keys built from all-ones and all-zero registers
		for (int kl = 0; kl < 4; kl++) begin
			write_reg(REG_KEY_LENGTH, 64'(kl));
			write_reg(REG_KEY_0_7, kl[0] ? '1 : '0);
			write_reg(REG_KEY_8_15, kl[0] ? '1 : '0);
			write_reg(REG_KEY_16_23, kl[0] ? '0 : '1);
			write_reg(REG_KEY_24_31, kl[0] ? '0 : '1);
			encrypt_block(1'b0, '1, '0);
			encrypt_block(1'b1, '0, '1);
			encrypt_block(1'b1, rand64(), rand64());
		end
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 10 : (ph == 1) ? 72 : 0;
			for (int k = 0; k < 4; k++) begin
				random_key();
				for (int n = 0; n < 70; n++)
					encrypt_block(1'($urandom), rand64(), rand64());
			end
		end
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
sv/aes_pkg.sv
sv/aes_key_sched.sv
sv/aes_round.sv
sv/aes_block_cipher_core.sv
sv/aes_core_checker.sv
sim/aes_block_cipher_checker.sv
sim/aes_block_cipher_core_tb.sv
